FILE: rtl/sida_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the slot ID allocator table.
package sida_pkg;

	localparam logic [1:0] REQ_PUT    = 2'd0;
	localparam logic [1:0] REQ_GET    = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;
	localparam logic [1:0] STAT_NULL  = 2'd3;

	localparam logic [6:0] CAPACITY_RESET = 7'd64;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [5:0]  slot_index;
		logic [31:0] object_handle;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  slot_id;
		logic [31:0] object_out;
		logic [6:0]  item_count;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} cmd_t;

	typedef enum logic {
		CTRL_IDLE,
		CTRL_EXEC
	} ctrl_state_t;

endpackage

FILE: rtl/sida_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module sida_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/sida_datapath.sv
`timescale 1ns / 1ps
// Datapath: capacity register, occupancy bitmap, handle store and result register.
module sida_datapath #(
	parameter int SLOTS       = 64,
	parameter int HANDLE_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sida_pkg::cmd_t cmd,
	input  sida_pkg::req_t req,
	input  logic          cfg_we,
	input  logic [6:0]    cfg_wdata,
	output logic          done,
	output sida_pkg::rsp_t rsp
);

	// Only slots below the largest capacity code can ever be reached.
	localparam int USED = (SLOTS < 127) ? SLOTS : 127;
	localparam int AW   = (USED > 1) ? $clog2(USED) : 1;
	localparam int HW   = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;

	logic [6:0]      capacity_q;
	logic [USED-1:0] valid_q;
	logic [6:0]      count_q;
	sida_pkg::req_t  req_q;
	sida_pkg::rsp_t  rsp_q;
	logic            done_q;

	logic [6:0]      lim;
	logic [15:0]     idx_w;
	logic [15:0]     cap_idx_w;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   ex_addr;
	logic [HW-1:0]   handle;
	logic            in_range;
	logic            found;
	logic [AW-1:0]   free_idx;
	logic [15:0]     free_w;
	logic [HW-1:0]   rdata;
	logic [63:0]     rdata_w;
	logic            slot_valid;
	logic            ram_we;
	logic            clear_slot;
	sida_pkg::rsp_t  rsp_d;

	assign lim       = (capacity_q > 7'(USED)) ? 7'(USED) : capacity_q;
	assign cap_idx_w = {10'd0, req.slot_index};
	assign rd_addr   = cap_idx_w[AW-1:0];
	assign idx_w     = {10'd0, req_q.slot_index};
	assign ex_addr   = idx_w[AW-1:0];
	assign handle    = req_q.object_handle[HW-1:0];
	assign in_range  = {1'b0, req_q.slot_index} < lim;
	assign slot_valid = valid_q[ex_addr];
	assign rdata_w   = 64'(rdata);
	assign free_w    = 16'(free_idx);

	always_comb begin
		found    = 1'b0;
		free_idx = '0;
		for (int i = USED - 1; i >= 0; i--) begin
			if (!valid_q[i] && (7'(i) < lim)) begin
				found    = 1'b1;
				free_idx = AW'(i);
			end
		end
	end

	always_comb begin
		rsp_d.status     = sida_pkg::STAT_OK;
		rsp_d.slot_id    = req_q.slot_index;
		rsp_d.object_out = '0;
		rsp_d.item_count = count_q;
		ram_we           = 1'b0;
		clear_slot       = 1'b0;
		unique case (req_q.req_type)
			sida_pkg::REQ_PUT: begin
				if (handle == '0) begin
					rsp_d.status = sida_pkg::STAT_NULL;
				end else if (found) begin
					ram_we           = cmd.execute;
					rsp_d.slot_id    = free_w[5:0];
					rsp_d.item_count = count_q + 7'd1;
				end else begin
					rsp_d.status = sida_pkg::STAT_FULL;
				end
			end
			sida_pkg::REQ_GET, sida_pkg::REQ_DELETE: begin
				if (!in_range) begin
					rsp_d.status = sida_pkg::STAT_RANGE;
				end else if (slot_valid) begin
					rsp_d.object_out = rdata_w[31:0];
					if (req_q.req_type == sida_pkg::REQ_DELETE) begin
						clear_slot       = cmd.execute;
						rsp_d.item_count = count_q - 7'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	sida_ram #(
		.WIDTH(HW),
		.DEPTH(USED)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_idx),
		.wdata (handle),
		.re    (cmd.capture),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= sida_pkg::CAPACITY_RESET;
			valid_q    <= '0;
			count_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (ram_we) begin
				valid_q[free_idx] <= 1'b1;
			end
			if (clear_slot) begin
				valid_q[ex_addr] <= 1'b0;
			end
			if (cmd.execute) begin
				count_q <= rsp_d.item_count;
			end
			done_q <= cmd.execute;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.execute) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: rtl/sida_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences capture and execution of a request.
module sida_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output sida_pkg::cmd_t cmd
);

	sida_pkg::ctrl_state_t state_q;
	sida_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sida_pkg::CTRL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		busy        = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		unique case (state_q)
			sida_pkg::CTRL_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = sida_pkg::CTRL_EXEC;
				end
			end
			sida_pkg::CTRL_EXEC: begin
				busy        = 1'b1;
				cmd.execute = 1'b1;
				state_d     = sida_pkg::CTRL_IDLE;
			end
			default: begin
				state_d = sida_pkg::CTRL_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/slot_id_allocator_table.sv
`timescale 1ns / 1ps
// Top level of the slot ID allocator table.
//
// A request is a transfer on start while busy is low. It carries a put, get or
// delete together with a slot index and an object handle. The block answers
// each request with exactly one result, shown on rsp for one cycle while done
// is high. The result gives a status, the slot ID, the handle read or removed
// and the count of occupied slots after the request.
// A request is captured in the cycle it is accepted, executed in the next cycle
// while busy is high, and its result appears in the cycle after that. A new
// request may be accepted in the same cycle as that result, but not earlier;
// execution follows capture as the handle store read is registered.
// A put takes the lowest free slot below the capacity, found by a priority
// search over the occupancy bitmap. The user must write the capacity register
// via cfg_we and cfg_wdata only while the block is idle; it is not enforced.
// Reset empties every slot at once by clearing the occupancy bitmap, sets the
// count to zero and the capacity to 64. The receiver cannot stall results.
module slot_id_allocator_table #(
	parameter int SLOTS       = 64,
	parameter int HANDLE_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  sida_pkg::req_t req,
	output logic           done,
	output sida_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic [6:0]     cfg_wdata
);

	sida_pkg::cmd_t cmd;

	sida_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	sida_datapath #(
		.SLOTS       (SLOTS),
		.HANDLE_BITS (HANDLE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.rsp       (rsp)
	);

endmodule

FILE: tb/slot_id_allocator_table_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the slot ID allocator table with a predicting shadow table.
module slot_id_allocator_table_test;

	localparam int SLOT_COUNT = 64;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 150;

	typedef enum {
		OP_REQUEST,
		OP_CAPACITY,
		OP_DRAIN,
		OP_PACE
	} op_kind_t;

	typedef struct {
		op_kind_t         kind;
		sida_pkg::req_t   payload;
		logic [6:0]       capacity;
		int               idle_pct;
	} pending_op_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           start = 1'b0;
	logic           busy;
	sida_pkg::req_t req = '0;
	logic           done;
	sida_pkg::rsp_t rsp;
	logic           cfg_we = 1'b0;
	logic [6:0]     cfg_wdata = sida_pkg::CAPACITY_RESET;

	pending_op_t    pending_ops[$];
	sida_pkg::rsp_t expected_rsps[$];
	logic [31:0]    shadow_handles[SLOT_COUNT] = '{default: '0};
	int             shadow_count = 0;
	int             shadow_capacity = sida_pkg::CAPACITY_RESET;
	int             sender_idle_pct = 0;
	int             mismatch_count = 0;

	int phase_caps[9] = '{64, 64, 5, 1, 127, 20, 37, 2, 64};
	int phase_puts[9] = '{80, 25, 55, 50, 60, 50, 70, 45, 50};
	int phase_pace[4] = '{0, 86, 0, 14};

	slot_id_allocator_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic sida_pkg::rsp_t predict_response(sida_pkg::req_t r);
		sida_pkg::rsp_t res;
		int             lim;
		int             slot;
		lim = (shadow_capacity > SLOT_COUNT) ? SLOT_COUNT : shadow_capacity;
		res.status = sida_pkg::STAT_OK;
		res.slot_id = r.slot_index;
		res.object_out = '0;
		case (r.req_type)
			sida_pkg::REQ_PUT: begin
				if (r.object_handle == '0) begin
					res.status = sida_pkg::STAT_NULL;
				end else begin
					slot = -1;
					for (int i = 0; i < lim; i++)
						if (slot < 0 && shadow_handles[i] == '0)
							slot = i;
					if (slot < 0) begin
						res.status = sida_pkg::STAT_FULL;
					end else begin
						shadow_handles[slot] = r.object_handle;
						shadow_count++;
						res.slot_id = 6'(slot);
					end
				end
			end
			sida_pkg::REQ_GET, sida_pkg::REQ_DELETE: begin
				if (int'(r.slot_index) >= lim) begin
					res.status = sida_pkg::STAT_RANGE;
				end else begin
					res.object_out = shadow_handles[r.slot_index];
					if (r.req_type == sida_pkg::REQ_DELETE && res.object_out != '0) begin
						shadow_handles[r.slot_index] = '0;
						shadow_count--;
					end
				end
			end
			default: ;
		endcase
		res.item_count = 7'(shadow_count);
		return res;
	endfunction

	task automatic log_error(string what, logic [31:0] want, logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: mismatch in %s: expected %h, got %h", $realtime, what, want, got);
	endtask

	task automatic queue_request(logic [1:0] kind, logic [5:0] idx, logic [31:0] handle);
		pending_op_t op;
		op.kind = OP_REQUEST;
		op.payload.req_type = kind;
		op.payload.slot_index = idx;
		op.payload.object_handle = handle;
		op.capacity = '0;
		op.idle_pct = 0;
		pending_ops.push_back(op);
	endtask

	task automatic queue_control(op_kind_t kind, logic [6:0] value, int pct);
		pending_op_t op;
		op.kind = kind;
		op.payload = '0;
		op.capacity = value;
		op.idle_pct = pct;
		pending_ops.push_back(op);
	endtask

	task automatic queue_random_requests(int count, int put_pct, int cap);
		int          reach;
		int          roll;
		logic [1:0]  kind;
		logic [5:0]  idx;
		logic [31:0] handle;
		reach = (cap > SLOT_COUNT) ? SLOT_COUNT : cap;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (roll < put_pct)
				kind = sida_pkg::REQ_PUT;
			else if (roll < put_pct + 4)
				kind = REQ_UNUSED;
			else
				kind = ($urandom_range(1) == 0) ? sida_pkg::REQ_GET : sida_pkg::REQ_DELETE;
			if (reach > 0 && $urandom_range(99) < 80)
				idx = 6'($urandom_range(reach - 1));
			else
				idx = 6'($urandom_range(SLOT_COUNT - 1));
			case ($urandom_range(9))
				0: handle = '0;
				1: handle = '1;
				2: handle = 32'd1 << $urandom_range(31);
				default: handle = $urandom;
			endcase
			queue_request(kind, idx, handle);
			if (n == count / 2 && put_pct < 40)
				queue_control(OP_DRAIN, '0, 0);
		end
	endtask

	always @(posedge clk) begin : driver
		logic hold;
		logic write_cap;
		if (arst_n) begin
			hold = start;
			write_cap = 1'b0;
			if (start && !busy) begin
				expected_rsps.push_back(predict_response(req));
				hold = 1'b0;
			end
			if (!hold && pending_ops.size() > 0) begin
				case (pending_ops[0].kind)
					OP_REQUEST: begin
						if ($urandom_range(99) >= sender_idle_pct) begin
							req <= pending_ops[0].payload;
							hold = 1'b1;
							void'(pending_ops.pop_front());
						end
					end
					OP_CAPACITY: begin
						if (expected_rsps.size() == 0) begin
							cfg_wdata <= pending_ops[0].capacity;
							shadow_capacity = pending_ops[0].capacity;
							write_cap = 1'b1;
							void'(pending_ops.pop_front());
						end
					end
					OP_DRAIN: begin
						if (expected_rsps.size() == 0)
							void'(pending_ops.pop_front());
					end
					OP_PACE: begin
						sender_idle_pct = pending_ops[0].idle_pct;
						void'(pending_ops.pop_front());
					end
				endcase
			end
			start <= hold;
			cfg_we <= write_cap;
		end
	end

	always @(posedge clk) begin : monitor
		sida_pkg::rsp_t want;
		if (arst_n) begin
			if ($isunknown(done)) begin
				log_error("done strobe", 32'd0, {31'd0, done});
			end else if (done) begin
				if (expected_rsps.size() == 0) begin
					log_error("transfer with no request outstanding, slot_id", 32'd0,
						{26'd0, rsp.slot_id});
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.status !== want.status)
						log_error("status", {30'd0, want.status}, {30'd0, rsp.status});
					if (rsp.slot_id !== want.slot_id)
						log_error("slot_id", {26'd0, want.slot_id}, {26'd0, rsp.slot_id});
					if (rsp.object_out !== want.object_out)
						log_error("object_out", want.object_out, rsp.object_out);
					if (rsp.item_count !== want.item_count)
						log_error("item_count", {25'd0, want.item_count},
							{25'd0, rsp.item_count});
				end
			end
		end
	end

	initial begin
		queue_request(sida_pkg::REQ_GET, 6'd0, 32'h0);
		queue_request(sida_pkg::REQ_DELETE, 6'd0, 32'h0);
		queue_request(sida_pkg::REQ_PUT, 6'd5, 32'h0);
		queue_request(sida_pkg::REQ_PUT, 6'd63, 32'hFFFF_FFFF);
		queue_request(sida_pkg::REQ_PUT, 6'd0, 32'h0000_0001);
		queue_request(sida_pkg::REQ_PUT, 6'd0, 32'h8000_0000);
		queue_request(sida_pkg::REQ_GET, 6'd63, 32'hFFFF_FFFF);
		queue_request(sida_pkg::REQ_GET, 6'd1, 32'h0);
		queue_request(sida_pkg::REQ_DELETE, 6'd1, 32'h0);
		queue_request(sida_pkg::REQ_PUT, 6'd0, 32'hA5A5_A5A5);
		queue_request(REQ_UNUSED, 6'd63, 32'hFFFF_FFFF);
		queue_control(OP_CAPACITY, 7'd0, 0);
		queue_request(sida_pkg::REQ_PUT, 6'd9, 32'h5A5A_5A5A);
		queue_request(sida_pkg::REQ_GET, 6'd0, 32'h0);
		queue_request(sida_pkg::REQ_DELETE, 6'd0, 32'h0);
		queue_control(OP_CAPACITY, 7'd2, 0);
		queue_request(sida_pkg::REQ_GET, 6'd2, 32'h0);
		queue_request(sida_pkg::REQ_PUT, 6'd3, 32'h1234_5678);
		queue_request(sida_pkg::REQ_DELETE, 6'd1, 32'h0);
		queue_request(sida_pkg::REQ_PUT, 6'd0, 32'h0000_FFFF);
		queue_control(OP_CAPACITY, 7'd127, 0);
		queue_request(sida_pkg::REQ_GET, 6'd2, 32'h0);
		queue_request(sida_pkg::REQ_GET, 6'd63, 32'h0);
		queue_request(sida_pkg::REQ_DELETE, 6'd2, 32'h0);
		queue_request(sida_pkg::REQ_DELETE, 6'd63, 32'h0);
		for (int p = 0; p < 9; p++) begin
			queue_control(OP_CAPACITY, 7'(phase_caps[p]), 0);
			queue_control(OP_PACE, '0, phase_pace[p % 4]);
			queue_random_requests(PHASE_ITEMS, phase_puts[p], phase_caps[p]);
		end

		while (pending_ops.size() != 0 || start || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_rsps.size() == 0)
			$display("slot_id_allocator_table_test: done, clean");
		else
			$display("slot_id_allocator_table_test: done, errors");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("slot_id_allocator_table_test: done, errors");
		$finish;
	end

endmodule
